// ===== rtl/core/swf_tag_stream_locator_core_defines.svh =====
// Assertion macros shared by the locator checker.
`ifndef SWF_TAG_STREAM_LOCATOR_CORE_DEFINES_SVH
`define SWF_TAG_STREAM_LOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STL_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("locator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define STL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("locator check failed in the following cycle");

`endif

// ===== rtl/core/stl_pkg.sv =====
// Shared types and constants of the tag stream locator.
`default_nettype none

package stl_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int TLEN_BITS   = 32;
	localparam int OUT_BITS    = 80;

	localparam logic [1:0] CFG_SEARCH_MODE   = 2'd0;
	localparam logic [1:0] CFG_TARGET_BUTTON = 2'd1;
	localparam logic [1:0] CFG_TARGET_FRAME  = 2'd2;

	localparam logic [1:0] MODE_BUTTON_OFFSET = 2'd0;
	localparam logic [1:0] MODE_FRAME_BOUNDS  = 2'd1;
	localparam logic [1:0] MODE_FIRST_BUTTON  = 2'd2;

	localparam logic [9:0] TAG_END        = 10'd0;
	localparam logic [9:0] TAG_SHOW_FRAME = 10'd1;
	localparam logic [9:0] TAG_BUTTON2    = 10'd34;

	localparam logic [5:0] LEN_LONG = 6'h3f;

	typedef struct packed {
		logic [1:0]  search_mode;
		logic [15:0] target_button_id;
		logic [15:0] target_frame;
	} stl_cfg_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] data_byte;
		logic       last_byte;
	} stl_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/stl_in_stage.sv =====
// Input register stage that holds one byte request for the parser.
`default_nettype none

module stl_in_stage
	import stl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic      s_tlast,
	input  wire logic      take,
	output stl_item_t      item
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// The stage frees up in the same cycle that the parser takes its content.
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
			byte_s1  <= s_tdata;
			last_s1  <= s_tlast;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	assign item = '{vld: valid_s1, data_byte: byte_s1, last_byte: last_s1};

endmodule

`default_nettype wire

// ===== rtl/core/stl_parser.sv =====
// Byte-wise file parser with the result register.
`default_nettype none

module stl_parser
	import stl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire stl_cfg_t              cfg,
	input  wire stl_item_t             item,
	output logic                       take,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_BITS-1:0]        m_tdata,
	output logic [0:0]                 m_tuser
);

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_RECT_FIRST,
		PH_RECT_REST,
		PH_RATE,
		PH_COUNT,
		PH_TAG_WORD,
		PH_TAG_LONG,
		PH_BUTTON_ID,
		PH_BODY,
		PH_DONE
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [OFFSET_BITS-1:0] byte_offset_q, byte_offset_d;
	logic [4:0]             rect_left_q, rect_left_d;
	logic [31:0]            shift_q, shift_d;
	logic [2:0]             field_left_q, field_left_d;
	logic [9:0]             tag_code_q, tag_code_d;
	logic [TLEN_BITS-1:0]   tag_left_q, tag_left_d;
	logic [OFFSET_BITS-1:0] tag_start_q, tag_start_d;
	logic [15:0]            frame_cnt_q, frame_cnt_d;
	logic [OFFSET_BITS-1:0] frame_start_q, frame_start_d;
	logic [OFFSET_BITS-1:0] tags_start_q, tags_start_d;
	logic [15:0]            hdr_frames_q, hdr_frames_d;
	logic                   done_q, done_d;

	logic                   out_valid_q;
	logic                   out_found_q;
	logic [31:0]            out_start_q, out_end_q;
	logic [15:0]            out_id_q;

	logic                   consume;
	logic                   hit;
	logic                   give;
	logic                   r_found;
	logic [31:0]            r_start, r_end;
	logic [15:0]            r_id;
	logic                   tag_fire;
	logic [TLEN_BITS-1:0]   tag_len;
	logic [9:0]             code_now;
	logic [31:0]            sh;
	logic [2:0]             field_dec;
	logic [TLEN_BITS-1:0]   tag_dec;
	logic [5:0]             rect_sum;
	logic [4:0]             rect_first;
	logic [15:0]            word;

	assign take    = !out_valid_q || m_tready;
	assign consume = item.vld && take;

	always_comb begin
		phase_d       = phase_q;
		byte_offset_d = byte_offset_q + OFFSET_BITS'(1);
		rect_left_d   = rect_left_q;
		shift_d       = shift_q;
		field_left_d  = field_left_q;
		tag_code_d    = tag_code_q;
		tag_left_d    = tag_left_q;
		tag_start_d   = tag_start_q;
		frame_cnt_d   = frame_cnt_q;
		frame_start_d = frame_start_q;
		tags_start_d  = tags_start_q;
		hdr_frames_d  = hdr_frames_q;
		done_d        = done_q;
		hit           = 1'b0;
		r_found       = 1'b0;
		r_start       = '0;
		r_end         = '0;
		r_id          = '0;
		tag_fire      = 1'b0;
		tag_len       = '0;
		code_now      = tag_code_q;
		sh            = {item.data_byte, shift_q[31:8]};
		field_dec     = field_left_q - 3'd1;
		tag_dec       = tag_left_q - TLEN_BITS'(1);
		word          = sh[31:16];
		// Rectangle size in bytes, minus the first one: ((12 + 4n) / 8) - 1.
		rect_sum      = {1'b0, item.data_byte[7:3]} + 6'd3;
		rect_first    = rect_sum[5:1] - 5'd1;

		case (phase_q)
			PH_HEADER: begin
				if (byte_offset_q >= OFFSET_BITS'(7)) phase_d = PH_RECT_FIRST;
			end
			PH_RECT_FIRST: begin
				rect_left_d  = rect_first;
				field_left_d = 3'd2;
				phase_d      = (rect_first != 5'd0) ? PH_RECT_REST : PH_RATE;
			end
			PH_RECT_REST: begin
				rect_left_d = rect_left_q - 5'd1;
				if (rect_left_q == 5'd1) begin
					phase_d      = PH_RATE;
					field_left_d = 3'd2;
				end
			end
			PH_RATE: begin
				field_left_d = field_dec;
				if (field_dec == 3'd0) begin
					phase_d      = PH_COUNT;
					field_left_d = 3'd2;
					shift_d      = '0;
				end
			end
			PH_COUNT: begin
				shift_d      = sh;
				field_left_d = field_dec;
				if (field_dec == 3'd0) begin
					hdr_frames_d  = word;
					tags_start_d  = byte_offset_q + OFFSET_BITS'(1);
					frame_start_d = byte_offset_q + OFFSET_BITS'(1);
					phase_d       = PH_TAG_WORD;
					field_left_d  = 3'd2;
					shift_d       = '0;
				end
			end
			PH_TAG_WORD: begin
				if (field_left_q == 3'd2) tag_start_d = byte_offset_q;
				shift_d      = sh;
				field_left_d = field_dec;
				if (field_dec == 3'd0) begin
					tag_code_d = word[15:6];
					code_now   = word[15:6];
					if (word[5:0] == LEN_LONG) begin
						phase_d      = PH_TAG_LONG;
						field_left_d = 3'd4;
						shift_d      = '0;
					end else begin
						tag_fire = 1'b1;
						tag_len  = TLEN_BITS'(word[5:0]);
					end
				end
			end
			PH_TAG_LONG: begin
				shift_d      = sh;
				field_left_d = field_dec;
				if (field_dec == 3'd0) begin
					tag_fire = 1'b1;
					tag_len  = sh;
				end
			end
			PH_BUTTON_ID: begin
				shift_d      = sh;
				tag_left_d   = tag_dec;
				field_left_d = field_dec;
				if (field_dec == 3'd0) begin
					if (cfg.search_mode == MODE_FIRST_BUTTON) begin
						hit     = 1'b1;
						r_found = 1'b1;
						r_id    = word;
					end else if (cfg.search_mode == MODE_BUTTON_OFFSET &&
							word == cfg.target_button_id) begin
						hit     = 1'b1;
						r_found = 1'b1;
						r_start = 32'(tag_start_q);
					end else if (tag_dec == '0) begin
						phase_d      = PH_TAG_WORD;
						field_left_d = 3'd2;
						shift_d      = '0;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				tag_left_d = tag_dec;
				if (tag_dec == '0) begin
					phase_d      = PH_TAG_WORD;
					field_left_d = 3'd2;
					shift_d      = '0;
				end
			end
			default: begin
			end
		endcase

		// A complete tag header: decide on the tag or choose how to walk it.
		if (tag_fire) begin
			tag_left_d = tag_len;
			if (code_now == TAG_END) begin
				hit = 1'b1;
				if (cfg.search_mode == MODE_FRAME_BOUNDS && hdr_frames_q == 16'd1) begin
					r_found = 1'b1;
					r_start = 32'(tags_start_q);
					r_end   = 32'(tag_start_q);
				end
			end else if (code_now == TAG_SHOW_FRAME &&
					cfg.search_mode == MODE_FRAME_BOUNDS &&
					frame_cnt_q == cfg.target_frame) begin
				hit     = 1'b1;
				r_found = 1'b1;
				r_start = 32'(frame_start_q);
				r_end   = 32'(tag_start_q);
			end else begin
				if (code_now == TAG_SHOW_FRAME && cfg.search_mode == MODE_FRAME_BOUNDS) begin
					frame_start_d = tag_start_q;
					frame_cnt_d   = frame_cnt_q + 16'd1;
				end
				if (code_now == TAG_BUTTON2 && tag_len >= TLEN_BITS'(2) &&
						(cfg.search_mode == MODE_BUTTON_OFFSET ||
						cfg.search_mode == MODE_FIRST_BUTTON)) begin
					phase_d      = PH_BUTTON_ID;
					field_left_d = 3'd2;
					shift_d      = '0;
				end else if (tag_len == '0) begin
					phase_d      = PH_TAG_WORD;
					field_left_d = 3'd2;
					shift_d      = '0;
				end else begin
					phase_d = PH_BODY;
				end
			end
		end

		if (hit) begin
			done_d  = 1'b1;
			phase_d = PH_DONE;
		end

		// A file without a decision still gets exactly one (negative) result.
		give = hit || (item.last_byte && !done_q);

		if (item.last_byte) begin
			phase_d       = PH_HEADER;
			byte_offset_d = '0;
			rect_left_d   = '0;
			shift_d       = '0;
			field_left_d  = '0;
			tag_code_d    = '0;
			tag_left_d    = '0;
			tag_start_d   = '0;
			frame_cnt_d   = '0;
			frame_start_d = '0;
			tags_start_d  = '0;
			hdr_frames_d  = '0;
			done_d        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			byte_offset_q <= '0;
			rect_left_q   <= '0;
			shift_q       <= '0;
			field_left_q  <= '0;
			tag_code_q    <= '0;
			tag_left_q    <= '0;
			tag_start_q   <= '0;
			frame_cnt_q   <= '0;
			frame_start_q <= '0;
			tags_start_q  <= '0;
			hdr_frames_q  <= '0;
			done_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			out_found_q   <= 1'b0;
			out_start_q   <= '0;
			out_end_q     <= '0;
			out_id_q      <= '0;
		end else begin
			if (consume) begin
				phase_q       <= phase_d;
				byte_offset_q <= byte_offset_d;
				rect_left_q   <= rect_left_d;
				shift_q       <= shift_d;
				field_left_q  <= field_left_d;
				tag_code_q    <= tag_code_d;
				tag_left_q    <= tag_left_d;
				tag_start_q   <= tag_start_d;
				frame_cnt_q   <= frame_cnt_d;
				frame_start_q <= frame_start_d;
				tags_start_q  <= tags_start_d;
				hdr_frames_q  <= hdr_frames_d;
				done_q        <= done_d;
			end
			if (consume && give) begin
				out_valid_q <= 1'b1;
				out_found_q <= r_found;
				out_start_q <= r_start;
				out_end_q   <= r_end;
				out_id_q    <= r_id;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_id_q, out_end_q, out_start_q};
	assign m_tuser  = out_found_q;

endmodule

`default_nettype wire

// ===== rtl/core/swf_tag_stream_locator_core.sv =====
// Top level of the tag stream locator: ports, configuration registers, stages.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  one file byte, s_tlast on the final byte
// m_*       out        m_tvalid / m_tready  one search result per file
// cfg_*     in         cfg_we (no wait)     register index and write data
//
// Every byte passes through the input register and then the parser; a new byte is
// taken in every cycle while results drain, so throughput is one byte per cycle.
// The rate is set by the single parser step between the two registers.
// Reset is asynchronous and active low; it clears the parser and all registers.
// When a result waits on m_tready, the input register holds one more byte and then
// s_tready falls until the result is taken.
`default_nettype none

module swf_tag_stream_locator_core
	import stl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Byte stream. s_tdata: data_byte[7:0]; s_tlast: last_byte.
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,
	input  wire logic                s_tlast,
	// Results. m_tdata: start_offset[31:0], end_offset[63:32], button_id[79:64].
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OUT_BITS-1:0]      m_tdata,
	// m_tuser: found[0].
	output logic [0:0]               m_tuser,
	// Configuration writes.
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);

	stl_cfg_t  cfg_q;
	stl_item_t item;
	logic      take;

	// Register writes act at once; a write to an index outside the map is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEARCH_MODE:   cfg_q.search_mode      <= cfg_data[1:0];
				CFG_TARGET_BUTTON: cfg_q.target_button_id <= cfg_data;
				CFG_TARGET_FRAME:  cfg_q.target_frame     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The input register holds one byte request ahead of the parser. While a result
	// waits and the input register is full, s_tready follows m_tready through the parser's take signal.
	stl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.item     (item)
	);

	// The parser walks header, rectangle and tags, and keeps the result register.
	stl_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item     (item),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== rtl/core/stl_checker.sv =====
// Port-level checker of the tag stream locator and its bind.
`default_nettype none
`include "swf_tag_stream_locator_core_defines.svh"

module stl_checker
	import stl_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OUT_BITS-1:0] m_tdata,
	input wire logic [0:0]          m_tuser
);

	// A stalled result keeps its content.
	`STL_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A negative result carries no offsets and no id.
	`STL_ASSERT_NOW(a_miss_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0)

	// A found result carries either offsets or a button id, never both.
	`STL_ASSERT_NOW(a_kind, clk, arst_n, m_tvalid && m_tuser[0], (m_tdata[79:64] == 16'd0) || (m_tdata[63:0] == 64'd0))

	// With no result pending the block always takes a request.
	`STL_ASSERT_NOW(a_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind swf_tag_stream_locator_core stl_checker u_stl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
